### rtl/assert_macros.svh
// Assertion macros used by the arbiter engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define QA_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("qarb assertion failed");
// Condition must never be seen at a clock edge out of reset.
`define QA_NEVER(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("qarb forbidden condition seen");
`else
`define QA_ASSERT(name, clk, rst_n, prop)
`define QA_NEVER(name, clk, rst_n, cond)
`endif
`endif

### rtl/qarb_pkg.sv
// Package: types and codes of the two-way quota alternation arbiter.
package qarb_pkg;

	localparam int COUNT_MAX_DEF = 255;
	localparam logic [7:0] QUOTA_RESET = 8'd1;

	// Event kinds
	localparam logic [1:0] KIND_ARRIVE = 2'd0;
	localparam logic [1:0] KIND_TRY    = 2'd1;
	localparam logic [1:0] KIND_LEAVE  = 2'd2;

	// Result status codes
	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_DENY = 2'd1;
	localparam logic [1:0] STATUS_ERR  = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic       side;
	} item_t;

	typedef struct packed {
		logic       granted;
		logic [1:0] status;
		logic       direction;
		logic [7:0] turn_count;
		logic [7:0] in_use_count;
		logic [7:0] left_waiting;
		logic [7:0] right_waiting;
	} result_t;

endpackage

### rtl/qarb_in_stage.sv
// Input register stage: holds one request beat until the engine takes it.
module qarb_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid,
	output logic            stall,
	input  qarb_pkg::item_t item,
	input  logic            take,
	output logic            item_valid_s1,
	output qarb_pkg::item_t item_s1
);

	logic load;

	// Refill when empty or when the held beat moves on this cycle
	assign load  = !item_valid_s1 || take;
	assign stall = item_valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (load) begin
			item_valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && valid) begin
			item_s1 <= item;
		end
	end

endmodule

### rtl/qarb_engine.sv
// Arbiter engine: state registers and the single-pass event update.
`include "assert_macros.svh"
module qarb_engine #(
	parameter int COUNT_MAX = qarb_pkg::COUNT_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              quota_we,
	input  logic [7:0]        quota_data,
	input  logic              take,
	input  qarb_pkg::item_t   item,
	output qarb_pkg::result_t res
);

	localparam logic [7:0] CNT_LIMIT = (COUNT_MAX < 255) ? 8'(COUNT_MAX) : 8'd255;

	typedef struct packed {
		logic       dir;
		logic [7:0] turn;
	} dir_turn_t;

	logic [7:0] quota_q;
	logic       dir_q;
	logic [7:0] turn_q;
	logic [7:0] holders_q;
	logic [7:0] wait_l_q;
	logic [7:0] wait_r_q;

	logic       dir_d;
	logic [7:0] turn_d;
	logic [7:0] holders_d;
	logic [7:0] wait_l_d;
	logic [7:0] wait_r_d;
	logic       granted;
	logic [1:0] status;
	logic [7:0] mine;
	dir_turn_t  try_rc;
	dir_turn_t  leave_rc;

	// Direction review: only while idle, flip on spent quota or empty side
	function automatic dir_turn_t reconsider(input logic [7:0] h, input logic d,
			input logic [7:0] t, input logic [7:0] wl, input logic [7:0] wr,
			input logic [7:0] q);
		dir_turn_t  r;
		logic [7:0] here;
		logic [7:0] there;
		logic       flip;
		here  = d ? wr : wl;
		there = d ? wl : wr;
		if (t >= q) begin
			flip = (there != 8'd0) || (here == 8'd0);
		end else begin
			flip = (here == 8'd0) && (there != 8'd0);
		end
		r.dir  = d;
		r.turn = t;
		if ((h == 8'd0) && flip) begin
			r.dir  = !d;
			r.turn = 8'd0;
		end
		return r;
	endfunction

	// Next state and result for the event in hand
	always_comb begin
		mine     = item.side ? wait_r_q : wait_l_q;
		try_rc   = reconsider(holders_q, dir_q, turn_q, wait_l_q, wait_r_q, quota_q);
		leave_rc = reconsider(holders_q - 8'd1, dir_q, turn_q, wait_l_q, wait_r_q,
			quota_q);
		dir_d     = dir_q;
		turn_d    = turn_q;
		holders_d = holders_q;
		wait_l_d  = wait_l_q;
		wait_r_d  = wait_r_q;
		granted   = 1'b0;
		status    = qarb_pkg::STATUS_OK;
		case (item.kind)
			qarb_pkg::KIND_ARRIVE: begin
				if (mine >= CNT_LIMIT) begin
					status = qarb_pkg::STATUS_ERR;
				end else if (item.side) begin
					wait_r_d = wait_r_q + 8'd1;
				end else begin
					wait_l_d = wait_l_q + 8'd1;
				end
			end
			qarb_pkg::KIND_TRY: begin
				if (mine == 8'd0) begin
					status = qarb_pkg::STATUS_ERR;
				end else if ((try_rc.dir == item.side) && (try_rc.turn < quota_q)) begin
					if (holders_q >= CNT_LIMIT) begin
						// overflow: direction review is dropped too
						status = qarb_pkg::STATUS_ERR;
					end else begin
						dir_d     = try_rc.dir;
						turn_d    = try_rc.turn + 8'd1;
						holders_d = holders_q + 8'd1;
						granted   = 1'b1;
						if (item.side) begin
							wait_r_d = wait_r_q - 8'd1;
						end else begin
							wait_l_d = wait_l_q - 8'd1;
						end
					end
				end else begin
					// denied, but a flip found on the way still stands
					status = qarb_pkg::STATUS_DENY;
					dir_d  = try_rc.dir;
					turn_d = try_rc.turn;
				end
			end
			qarb_pkg::KIND_LEAVE: begin
				if (holders_q == 8'd0) begin
					status = qarb_pkg::STATUS_ERR;
				end else begin
					holders_d = holders_q - 8'd1;
					dir_d     = leave_rc.dir;
					turn_d    = leave_rc.turn;
				end
			end
			default: begin
				status = qarb_pkg::STATUS_ERR;
			end
		endcase
	end

	assign res.granted       = granted;
	assign res.status        = status;
	assign res.direction     = dir_d;
	assign res.turn_count    = turn_d;
	assign res.in_use_count  = holders_d;
	assign res.left_waiting  = wait_l_d;
	assign res.right_waiting = wait_r_d;

	// Quota register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quota_q <= qarb_pkg::QUOTA_RESET;
		end else if (quota_we) begin
			quota_q <= quota_data;
		end
	end

	// Arbiter state, stepped once per taken beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q     <= 1'b0;
			turn_q    <= 8'd0;
			holders_q <= 8'd0;
			wait_l_q  <= 8'd0;
			wait_r_q  <= 8'd0;
		end else if (take) begin
			dir_q     <= dir_d;
			turn_q    <= turn_d;
			holders_q <= holders_d;
			wait_l_q  <= wait_l_d;
			wait_r_q  <= wait_r_d;
		end
	end

	`QA_NEVER(a_holders_limit, clk, arst_n, holders_q > CNT_LIMIT)
	`QA_NEVER(a_wait_limit, clk, arst_n, (wait_l_q > CNT_LIMIT) || (wait_r_q > CNT_LIMIT))
	`QA_ASSERT(a_grant_ok, clk, arst_n, granted |-> ((status == qarb_pkg::STATUS_OK) && (item.kind == qarb_pkg::KIND_TRY)))
	`QA_ASSERT(a_hold_idle, clk, arst_n, !take |=> ($stable(holders_q) && $stable(dir_q)))
	`QA_ASSERT(a_err_keeps, clk, arst_n, (take && (status == qarb_pkg::STATUS_ERR)) |=> ($stable(turn_q) && $stable(wait_l_q) && $stable(wait_r_q)))

endmodule

### rtl/qarb_out_stage.sv
// Result register: holds one result beat until the receiver takes it.
module qarb_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid_s1,
	input  qarb_pkg::result_t res,
	output logic              take,
	output logic              valid,
	input  logic              stall,
	output qarb_pkg::result_t rsp_q
);

	// Engine result moves in when the register is empty or being drained
	assign take = item_valid_s1 && (!valid || !stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else if (take) begin
			valid <= 1'b1;
		end else if (!stall) begin
			valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q <= res;
		end
	end

endmodule

### rtl/two_way_quota_alternation_arbiter_top.sv
// Top level of the two-way quota alternation arbiter.
// Request channel: req_valid / req_stall with req (kind, side). Each beat is an
// event: arrive and wait, try to enter, or leave the resource.
// Response channel: rsp_valid / rsp_stall with rsp. Exactly one result beat
// comes back per request beat, in order: grant flag, status, and the
// direction and counters as they stand after the event.
// quota_we / quota_data write the turn quota; write it only while idle.
// A request beat is held in the request register, and its result is captured
// in the result register before it shows on rsp.
// Throughput: one event per cycle while rsp_stall is low, set by the
// single-pass state update between the request and result registers.
// Reset (arst_n low): direction left to right, all counters zero, quota 1, both
// pipeline registers empty.
// A stalled response holds its beat; the request register then holds too, and
// req_stall rises once it is full.
module two_way_quota_alternation_arbiter_top #(
	parameter int COUNT_MAX = qarb_pkg::COUNT_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              quota_we,
	input  logic [7:0]        quota_data,
	input  logic              req_valid,
	output logic              req_stall,
	input  qarb_pkg::item_t   req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output qarb_pkg::result_t rsp
);

	logic              take;
	logic              item_valid_s1;
	qarb_pkg::item_t   item_s1;
	qarb_pkg::result_t res;

	// Request register
	qarb_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid         (req_valid),
		.stall         (req_stall),
		.item          (req),
		.take          (take),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1)
	);

	// State update
	qarb_engine #(
		.COUNT_MAX (COUNT_MAX)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.quota_we   (quota_we),
		.quota_data (quota_data),
		.take       (take),
		.item       (item_s1),
		.res        (res)
	);

	// Result register
	qarb_out_stage u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid_s1 (item_valid_s1),
		.res           (res),
		.take          (take),
		.valid         (rsp_valid),
		.stall         (rsp_stall),
		.rsp_q         (rsp)
	);

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the two-way quota alternation arbiter top level.
`timescale 1ns / 1ps

module testbench;

	localparam int CLK_HALF = 6;
	localparam int IDLE_LIMIT = 2000;
	localparam int REPORT_MAX = 10;
	localparam int COUNT_LIMIT = (qarb_pkg::COUNT_MAX_DEF < 255) ? qarb_pkg::COUNT_MAX_DEF : 255;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic SIDE_LEFT = 1'b0;
	localparam logic SIDE_RIGHT = 1'b1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic quota_we = 1'b0;
	logic [7:0] quota_data = '0;
	logic req_valid = 1'b0;
	logic req_stall;
	qarb_pkg::item_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	qarb_pkg::result_t rsp;

	// Shadow of the arbiter state, advanced at each accepted request beat
	logic arb_dir;
	logic [7:0] arb_turn;
	logic [7:0] arb_holders;
	logic [7:0] arb_wait [2];
	logic [7:0] arb_quota;

	qarb_pkg::result_t pending_results [$];

	int gap_max = 13;
	int stall_max = 13;
	int hold_request = 0;
	int fail_count = 0;
	int mismatch_count = 0;
	int idle_cycles = 0;

	two_way_quota_alternation_arbiter_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.quota_we(quota_we),
		.quota_data(quota_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #CLK_HALF clk = ~clk;

	// Direction re-evaluation, only while nobody holds the resource
	function automatic void settle_direction();
		logic [7:0] here;
		logic [7:0] there;
		logic flip;
		here = arb_wait[arb_dir];
		there = arb_wait[~arb_dir];
		if (arb_holders == 0) begin
			if (arb_turn >= arb_quota)
				flip = (there != 0) || (here == 0);
			else
				flip = (here == 0) && (there != 0);
			if (flip) begin
				arb_dir = ~arb_dir;
				arb_turn = '0;
			end
		end
	endfunction

	// Expected result of one event; updates the shadow state
	function automatic qarb_pkg::result_t arbitrate_event(input qarb_pkg::item_t ev);
		qarb_pkg::result_t r;
		logic s;
		logic save_dir;
		logic [7:0] save_turn;
		r = '0;
		r.status = qarb_pkg::STATUS_OK;
		s = ev.side;
		case (ev.kind)
			qarb_pkg::KIND_ARRIVE: begin
				if (arb_wait[s] >= COUNT_LIMIT)
					r.status = qarb_pkg::STATUS_ERR;
				else
					arb_wait[s] = arb_wait[s] + 8'd1;
			end
			qarb_pkg::KIND_TRY: begin
				if (arb_wait[s] == 0) begin
					r.status = qarb_pkg::STATUS_ERR;
				end else begin
					save_dir = arb_dir;
					save_turn = arb_turn;
					settle_direction();
					if (arb_dir == s && arb_turn < arb_quota) begin
						if (arb_holders >= COUNT_LIMIT) begin
							// holder count full: roll back any flip
							arb_dir = save_dir;
							arb_turn = save_turn;
							r.status = qarb_pkg::STATUS_ERR;
						end else begin
							arb_turn = arb_turn + 8'd1;
							arb_holders = arb_holders + 8'd1;
							arb_wait[s] = arb_wait[s] - 8'd1;
							r.granted = 1'b1;
						end
					end else begin
						r.status = qarb_pkg::STATUS_DENY;
					end
				end
			end
			qarb_pkg::KIND_LEAVE: begin
				if (arb_holders == 0) begin
					r.status = qarb_pkg::STATUS_ERR;
				end else begin
					arb_holders = arb_holders - 8'd1;
					settle_direction();
				end
			end
			default: r.status = qarb_pkg::STATUS_ERR;
		endcase
		r.direction = arb_dir;
		r.turn_count = arb_turn;
		r.in_use_count = arb_holders;
		r.left_waiting = arb_wait[SIDE_LEFT];
		r.right_waiting = arb_wait[SIDE_RIGHT];
		return r;
	endfunction

	// Offer one request beat after a random gap; valid stays high afterwards
	task automatic send_event(input logic [1:0] kind, input logic side);
		int gap;
		qarb_pkg::item_t ev;
		gap = $urandom_range(0, gap_max);
		ev.kind = kind;
		ev.side = side;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= ev;
		do @(posedge clk); while (req_stall);
		pending_results.push_back(arbitrate_event(ev));
	endtask

	// Stop offering and wait until every expected beat has come back
	task automatic drain_results();
		req_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Quota write, only while the block is idle
	task automatic set_quota(input logic [7:0] q);
		drain_results();
		quota_we <= 1'b1;
		quota_data <= q;
		@(posedge clk);
		quota_we <= 1'b0;
		arb_quota = q;
	endtask

	task automatic send_repeated(input logic [1:0] kind, input logic side, input int n);
		for (int i = 0; i < n; i++)
			send_event(kind, side);
	endtask

	// Error events, a full turn each way and flips after the last holder leaves
	task automatic test_directed_basics();
		send_event(qarb_pkg::KIND_TRY, SIDE_LEFT);
		send_event(qarb_pkg::KIND_LEAVE, SIDE_LEFT);
		send_event(KIND_UNUSED, SIDE_RIGHT);
		send_event(KIND_UNUSED, SIDE_LEFT);
		send_event(qarb_pkg::KIND_ARRIVE, SIDE_LEFT);
		send_event(qarb_pkg::KIND_ARRIVE, SIDE_RIGHT);
		send_event(qarb_pkg::KIND_TRY, SIDE_RIGHT);
		send_event(qarb_pkg::KIND_TRY, SIDE_LEFT);
		send_event(qarb_pkg::KIND_TRY, SIDE_RIGHT);
		send_event(qarb_pkg::KIND_ARRIVE, SIDE_LEFT);
		send_event(qarb_pkg::KIND_LEAVE, SIDE_RIGHT);
		send_event(qarb_pkg::KIND_TRY, SIDE_LEFT);
		send_event(qarb_pkg::KIND_TRY, SIDE_RIGHT);
		send_event(qarb_pkg::KIND_LEAVE, SIDE_LEFT);
		send_event(qarb_pkg::KIND_TRY, SIDE_LEFT);
		send_event(qarb_pkg::KIND_LEAVE, SIDE_RIGHT);
		send_event(qarb_pkg::KIND_LEAVE, SIDE_LEFT);
		send_event(qarb_pkg::KIND_ARRIVE, SIDE_LEFT);
		send_event(qarb_pkg::KIND_TRY, SIDE_LEFT);
		send_event(qarb_pkg::KIND_LEAVE, SIDE_LEFT);
	endtask

	// Quota of zero: never granted, a denied try may still flip the direction
	task automatic test_zero_quota();
		set_quota(8'd0);
		send_event(qarb_pkg::KIND_ARRIVE, SIDE_LEFT);
		send_event(qarb_pkg::KIND_ARRIVE, SIDE_RIGHT);
		send_event(qarb_pkg::KIND_TRY, SIDE_LEFT);
		send_event(qarb_pkg::KIND_TRY, SIDE_RIGHT);
		send_event(qarb_pkg::KIND_TRY, SIDE_RIGHT);
		send_event(qarb_pkg::KIND_LEAVE, SIDE_RIGHT);
	endtask

	// Left waiting count runs into its limit, then a few grants and leaves
	task automatic test_counter_saturation();
		gap_max = 2;
		stall_max = 2;
		set_quota(8'd255);
		send_repeated(qarb_pkg::KIND_ARRIVE, SIDE_LEFT, COUNT_LIMIT + 1);
		send_repeated(qarb_pkg::KIND_TRY, SIDE_LEFT, 6);
		send_repeated(qarb_pkg::KIND_LEAVE, SIDE_LEFT, 4);
	endtask

	// Receiver holds off while back-to-back requests fill the block
	task automatic test_backpressure();
		gap_max = 0;
		stall_max = 3;
		set_quota(8'd2);
		hold_request = 60;
		for (int i = 0; i < 30; i++)
			send_event(i % 3 == 2 ? qarb_pkg::KIND_TRY : qarb_pkg::KIND_ARRIVE,
				1'($urandom_range(0, 1)));
	endtask

	// Random event mix over several quotas and idling patterns
	task automatic test_random_traffic();
		logic [7:0] quotas [5];
		int pick;
		logic [1:0] kind;
		quotas[0] = 8'd1;
		quotas[1] = 8'd3;
		quotas[2] = 8'd255;
		quotas[3] = 8'($urandom_range(2, 254));
		quotas[4] = 8'd2;
		for (int ph = 0; ph < 5; ph++) begin
			gap_max = (ph == 1) ? 0 : 13;
			stall_max = (ph == 1 || ph == 3) ? 0 : 13;
			set_quota(quotas[ph]);
			for (int i = 0; i < 16; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 38)
					kind = qarb_pkg::KIND_ARRIVE;
				else if (pick < 78)
					kind = qarb_pkg::KIND_TRY;
				else if (pick < 96)
					kind = qarb_pkg::KIND_LEAVE;
				else
					kind = KIND_UNUSED;
				send_event(kind, 1'($urandom_range(0, 1)));
			end
		end
	endtask

	// Result receiver: random stall per beat, or a long hold when requested
	initial begin
		int n;
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_request > 0) begin
				n = hold_request;
				hold_request = 0;
			end else begin
				n = $urandom_range(0, stall_max);
			end
			if (n > 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
				rsp_stall <= 1'b0;
			end
			do @(posedge clk); while (!rsp_valid || rsp_stall);
		end
	end

	// Result check against the oldest expectation
	always @(posedge clk) begin
		qarb_pkg::result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				fail_count++;
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("unexpected result beat: g=%0d s=%0d d=%0d t=%0d u=%0d l=%0d r=%0d",
						rsp.granted, rsp.status, rsp.direction, rsp.turn_count,
						rsp.in_use_count, rsp.left_waiting, rsp.right_waiting);
			end else begin
				want = pending_results.pop_front();
				if (rsp !== want) begin
					fail_count++;
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX) begin
						$display("mismatch want: g=%0d s=%0d d=%0d t=%0d u=%0d l=%0d r=%0d",
							want.granted, want.status, want.direction, want.turn_count,
							want.in_use_count, want.left_waiting, want.right_waiting);
						$display("         got:  g=%0d s=%0d d=%0d t=%0d u=%0d l=%0d r=%0d",
							rsp.granted, rsp.status, rsp.direction, rsp.turn_count,
							rsp.in_use_count, rsp.left_waiting, rsp.right_waiting);
					end
				end
			end
		end
	end

	// Watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("two_way_quota_alternation_arbiter_top regression: fail");
				$finish;
			end
		end
	end

	initial begin
		arb_dir = 1'b0;
		arb_turn = '0;
		arb_holders = '0;
		arb_wait[SIDE_LEFT] = '0;
		arb_wait[SIDE_RIGHT] = '0;
		arb_quota = qarb_pkg::QUOTA_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_basics();
		test_zero_quota();
		test_counter_saturation();
		test_backpressure();
		test_random_traffic();

		drain_results();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("two_way_quota_alternation_arbiter_top regression: pass");
		else
			$display("two_way_quota_alternation_arbiter_top regression: fail");
		$finish;
	end

endmodule
